FILE: rtl/core/assert_macros.svh
// Assertion shorthands for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/core/lirs_pkg.sv
package lirs_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int STEP_W    = 18;
    localparam int ACC_W     = 19;
    localparam int FRAC_BITS = 16;
    localparam int DIFF_W    = SAMPLE_W + 1;
    localparam int PROD_W    = FRAC_BITS + 1 + DIFF_W;
    localparam int SUM_W     = PROD_W + 1;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [STEP_W-1:0]          step_t;
    typedef logic [ACC_W-1:0]           acc_t;

    localparam acc_t  ONE_POS       = acc_t'(1) << FRAC_BITS;
    localparam acc_t  TWO_POS       = acc_t'(2) << FRAC_BITS;
    localparam step_t MIN_STEP      = step_t'(1) << (FRAC_BITS - 3);
    localparam step_t STEP_RESET    = step_t'(60211);

    // Word index of the phase step register (byte address 0).
    localparam logic [APB_ADDR_W-3:0] REG_PHASE_STEP = '0;

endpackage

FILE: rtl/core/linear_interp_resampler.sv
// Each interpolated word is worked out in the ST_SEG and ST_SUM states and registered
// on the output; at stream end, ST_TAIL then offers the final input as repeats (directly
// after acceptance when the final input is also the stream's first).
// s_ready is low outside ST_IDLE, so an input holds off the next one until all its words
// and repeats are out, output stalls included.
// Reset: synchronous, active low; clears stream state and output valid, phase_step = 60211.
module linear_interp_resampler (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lirs_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [lirs_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [lirs_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  lirs_pkg::sample_t                    s_sample_in,
    input  logic                                 s_is_final,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output lirs_pkg::sample_t                    m_sample_out,
    output logic                                 m_run_end,
    output logic                                 m_stream_end
);
    import lirs_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SEG  = 2'd1;
    localparam logic [1:0] ST_SUM  = 2'd2;
    localparam logic [1:0] ST_TAIL = 2'd3;

    logic [1:0]                state_reg, state_next;
    step_t                     step_reg, step_next;
    sample_t                   prev_reg, prev_next;
    logic                      have_prev_reg, have_prev_next;
    acc_t                      acc_reg, acc_next;
    sample_t                   cur_reg, cur_next;
    logic                      fin_reg, fin_next;
    logic signed [DIFF_W-1:0]  diff_reg, diff_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic                      m_valid_reg, m_valid_next;
    sample_t                   m_sample_reg, m_sample_next;
    logic                      m_run_end_reg, m_run_end_next;
    logic                      m_stream_end_reg, m_stream_end_next;

    step_t                     eff_step;
    acc_t                      acc_adv;
    logic                      acc_lt_one;
    logic                      adv_ge_one;
    logic                      adv_ge_two;
    logic                      out_free;
    logic                      cfg_wr;
    logic signed [FRAC_BITS:0] mul_a;
    logic signed [SUM_W-1:0]   left_scaled;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   quo;
    logic                      round_up;
    sample_t                   interp;

    assign eff_step   = (step_reg < MIN_STEP) ? MIN_STEP : step_reg;
    // The accumulator is below one whenever it is advanced, so 19 bits never overflow.
    assign acc_adv    = acc_reg + ACC_W'(eff_step);
    assign acc_lt_one = acc_reg < ONE_POS;
    assign adv_ge_one = acc_adv >= ONE_POS;
    assign adv_ge_two = acc_adv >= TWO_POS;
    assign out_free   = !m_valid_reg || m_ready;
    assign cfg_wr     = psel && penable && pwrite;
    assign mul_a      = $signed({1'b0, acc_reg[FRAC_BITS-1:0]});

    // prev * ONE + a * (cur - prev), divided by ONE with truncation toward zero.
    assign left_scaled = $signed({{(SUM_W - SAMPLE_W - FRAC_BITS){prev_reg[SAMPLE_W-1]}},
                                  prev_reg, {FRAC_BITS{1'b0}}});
    assign sum         = left_scaled + $signed({prod_reg[PROD_W-1], prod_reg});
    assign quo         = sum >>> FRAC_BITS;
    assign round_up    = sum[SUM_W-1] && (sum[FRAC_BITS-1:0] != '0);
    assign interp      = sample_t'(quo[SAMPLE_W-1:0] + {{(SAMPLE_W-1){1'b0}}, round_up});

    assign pready       = 1'b1;
    assign prdata       = (paddr[APB_ADDR_W-1:2] == REG_PHASE_STEP)
                        ? {{(APB_DATA_W - STEP_W){1'b0}}, step_reg} : '0;
    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_reg;
    assign m_run_end    = m_run_end_reg;
    assign m_stream_end = m_stream_end_reg;

    always_comb begin
        state_next        = state_reg;
        step_next         = step_reg;
        prev_next         = prev_reg;
        have_prev_next    = have_prev_reg;
        acc_next          = acc_reg;
        cur_next          = cur_reg;
        fin_next          = fin_reg;
        diff_next         = diff_reg;
        prod_next         = prod_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_sample_next     = m_sample_reg;
        m_run_end_next    = m_run_end_reg;
        m_stream_end_next = m_stream_end_reg;

        if (cfg_wr && paddr[APB_ADDR_W-1:2] == REG_PHASE_STEP) begin
            step_next = pwdata[STEP_W-1:0];
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cur_next  = s_sample_in;
                    fin_next  = s_is_final;
                    diff_next = $signed({s_sample_in[SAMPLE_W-1], s_sample_in})
                              - $signed({prev_reg[SAMPLE_W-1], prev_reg});
                    if (have_prev_reg) begin
                        state_next = ST_SEG;
                    end else if (s_is_final) begin
                        state_next = ST_TAIL;
                    end else begin
                        prev_next      = s_sample_in;
                        have_prev_next = 1'b1;
                    end
                end
            end
            ST_SEG: begin
                if (acc_lt_one) begin
                    prod_next  = mul_a * diff_reg;
                    state_next = ST_SUM;
                end else begin
                    // The segment is done; the position is now measured from this word.
                    acc_next       = acc_reg - ONE_POS;
                    prev_next      = cur_reg;
                    have_prev_next = 1'b1;
                    state_next     = fin_reg ? ST_TAIL : ST_IDLE;
                end
            end
            ST_SUM: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_sample_next = interp;
                    // Last of this input when the segment ends and no repeats follow.
                    m_run_end_next    = adv_ge_one && (!fin_reg || adv_ge_two);
                    m_stream_end_next = adv_ge_one && fin_reg && adv_ge_two;
                    acc_next          = acc_adv;
                    state_next        = ST_SEG;
                end
            end
            ST_TAIL: begin
                if (acc_lt_one) begin
                    if (out_free) begin
                        m_valid_next      = 1'b1;
                        m_sample_next     = cur_reg;
                        m_run_end_next    = adv_ge_one;
                        m_stream_end_next = adv_ge_one;
                        acc_next          = acc_adv;
                    end
                end else begin
                    prev_next      = '0;
                    acc_next       = '0;
                    have_prev_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_RESET;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            acc_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            acc_reg       <= acc_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg          <= cur_next;
        fin_reg          <= fin_next;
        diff_reg         <= diff_next;
        prod_reg         <= prod_next;
        m_sample_reg     <= m_sample_next;
        m_run_end_reg    <= m_run_end_next;
        m_stream_end_reg <= m_stream_end_next;
    end

endmodule

FILE: rtl/core/lirs_checker.sv
`include "assert_macros.svh"

module lirs_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              s_is_final,
    input logic              m_valid,
    input logic              m_ready,
    input lirs_pkg::sample_t m_sample_out,
    input logic              m_run_end,
    input logic              m_stream_end
);
    import lirs_pkg::*;

    // A stalled output word stays offered and unchanged.
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `ASSERT_NEXT(a_out_stable, aclk, aresetn, m_valid && !m_ready, $stable(m_sample_out))

    // The end of a stream is always also the end of that input's run.
    `ASSERT_IMPL(a_stream_run, aclk, aresetn, m_valid && m_stream_end, m_run_end)

    // Accepting a final word always leaves the block busy, so s_ready goes low.
    `ASSERT_NEXT(a_final_busy, aclk, aresetn, s_valid && s_ready && s_is_final, !s_ready)

endmodule

bind linear_interp_resampler lirs_checker u_lirs_checker (.*);
